### sv/tos_pkg.sv
package tos_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 24;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 48;
  localparam int MAX_TERMS = 16;
  localparam int IDX_W     = $clog2(MAX_TERMS);

  // configuration register file
  localparam int STEP_W   = 31;
  localparam int TC_W     = 5;
  localparam int ADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_STEP  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIR   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TERMS = 2'd2;
  localparam logic [STEP_W-1:0] STEP_RST  = 31'd1677722;
  localparam logic [TC_W-1:0]   TERMS_RST = 5'd10;

  // divider: magnitude of a 33-bit difference, several quotient bits per cycle
  localparam int DIV_IN_W = DATA_W + 1;
  localparam int DIV_STEP = 8;
  localparam int DIV_CYC  = (DIV_IN_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W    = DIV_CYC * DIV_STEP;
  localparam int DIVC_W   = $clog2(DIV_CYC);

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // round to nearest, ties toward +inf, then drop the fraction
  function automatic logic signed [ACC_W-1:0] q_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + RND_HALF;
    t = t >>> FRAC_BITS;
    return t[ACC_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > SAT_MAX) r = SAT_MAX;
    if (v < SAT_MIN) r = SAT_MIN;
    return r[DATA_W-1:0];
  endfunction

  function automatic logic sat_hit(input logic signed [ACC_W-1:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

endpackage

### sv/tos_div.sv
module tos_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tos_pkg::DIV_IN_W-1:0]  dividend,
  input  logic [tos_pkg::IDX_W-1:0]     divisor,
  output logic                          done,
  output logic [tos_pkg::DIV_IN_W-1:0]  quotient
);

  logic [tos_pkg::DIV_W-1:0]  work;
  logic [tos_pkg::DIV_W-1:0]  work_next;
  logic [tos_pkg::IDX_W-1:0]  rem;
  logic [tos_pkg::IDX_W-1:0]  rem_next;
  logic [tos_pkg::DIVC_W-1:0] cnt;
  logic                       busy;

  // restoring division, DIV_STEP quotient bits per cycle; quotient shifts in behind
  always_comb begin
    logic [tos_pkg::IDX_W:0] t;
    work_next = work;
    rem_next  = rem;
    for (int s = 0; s < tos_pkg::DIV_STEP; s++) begin
      t = {rem_next, work_next[tos_pkg::DIV_W-1]};
      work_next = {work_next[tos_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        work_next[0] = 1'b1;
      end
      rem_next = t[tos_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        work <= tos_pkg::DIV_W'(dividend);
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        work <= work_next;
        rem  <= rem_next;
        if (cnt == tos_pkg::DIVC_W'(tos_pkg::DIV_CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt  <= cnt + 1'b1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quotient = work[tos_pkg::DIV_IN_W-1:0];

endmodule

### sv/taylor_ode_step_top.sv
// channel   direction  handshake               payload
// cfg       in/out     psel, penable, pready    paddr, pwdata, prdata
// in        in         in_valid, in_stall       x_now
// out       out        out_valid, out_stall     x_next, slope_next, overflow
//
// Each item's run time is set by the single 32x32 multiply-accumulate that runs every
// Cauchy product term and every Horner step, plus the multi-bit-per-cycle divider for
// each new coefficient.
// in_stall is high from acceptance until the result is loaded into the output register;
// a result waiting under out_stall does not block the next item until its own result.
// Synchronous reset loads the register reset values and empties the pipeline.
module taylor_ode_step_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tos_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tos_pkg::DATA_W-1:0] x_now,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tos_pkg::DATA_W-1:0] x_next,
  output logic signed [tos_pkg::DATA_W-1:0] slope_next,
  output logic                              overflow
);

  typedef enum logic {K_SQ, K_CU} kind_t;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    kind_t kind;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_CU, S_DRAIN, S_PREP, S_DIVW, S_DCOEF, S_HMUL, S_HADD, S_FIN
  } state_t;

  localparam logic [1:0] HOLD_GAP = 2'd2;

  state_t state;

  // configuration
  logic [tos_pkg::STEP_W-1:0] step_size;
  logic                       backward;
  logic [tos_pkg::TC_W-1:0]   term_count;
  logic                       cfg_wr;
  logic [tos_pkg::REG_IDX_W-1:0] cfg_idx;

  // sequencer
  logic [tos_pkg::IDX_W-1:0] k, i, nm1, hk, nm1_in, dnum, half;
  logic [1:0]                hold;
  logic                      phase;
  logic                      accept;
  logic                      ovf, ovf_set;

  // memories
  logic signed [tos_pkg::DATA_W-1:0] cmem  [tos_pkg::MAX_TERMS];
  logic signed [tos_pkg::DATA_W-1:0] sqmem [tos_pkg::MAX_TERMS];
  logic signed [tos_pkg::DATA_W-1:0] dcmem [tos_pkg::MAX_TERMS];
  logic signed [tos_pkg::DATA_W-1:0] rd_ca, rd_cb, rd_sq, rd_dc;
  logic [tos_pkg::IDX_W-1:0]         addr_a, addr_b, c_waddr;
  logic                              c_we, sq_we;
  logic signed [tos_pkg::DATA_W-1:0] c_wdata;

  // multiply-accumulate pipeline
  mac_ctl_t iss, ctl_b, ctl_c;
  logic signed [tos_pkg::DATA_W-1:0] mul_a, mul_b, h;
  logic signed [tos_pkg::PROD_W-1:0] prod;
  logic signed [tos_pkg::ACC_W-1:0]  acc, acc_base, q, sum;
  logic signed [tos_pkg::DATA_W-1:0] sum_sat;
  logic                              sum_hit;
  logic signed [tos_pkg::DATA_W-1:0] sq_last, cu_last;
  logic                              cu_done;

  // coefficient update
  logic signed [tos_pkg::DATA_W:0]   diff;
  logic [tos_pkg::DIV_IN_W-1:0]      mag;
  logic                              div_start, div_done;
  logic [tos_pkg::DIV_IN_W-1:0]      div_q;
  logic signed [tos_pkg::ACC_W-1:0]  div_val;
  logic signed [tos_pkg::DATA_W-1:0] c_new;
  logic signed [tos_pkg::DATA_W+tos_pkg::IDX_W:0] dc_prod;
  logic signed [tos_pkg::ACC_W-1:0]  dc_val;

  // Horner
  logic signed [tos_pkg::DATA_W-1:0] hv, x_res, slope_res, hv_new;
  logic signed [tos_pkg::ACC_W-1:0]  hv_sum, term;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[tos_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      tos_pkg::REG_STEP:  prdata = {1'b0, step_size};
      tos_pkg::REG_DIR:   prdata = {31'b0, backward};
      tos_pkg::REG_TERMS: prdata = {27'b0, term_count};
      default:            prdata = '0;
    endcase
  end

  assign h = backward ? -$signed({1'b0, step_size}) : $signed({1'b0, step_size});

  // clamp the term count to 2..MAX_TERMS, hold n-1
  always_comb begin
    if (int'(term_count) < 2)
      nm1_in = tos_pkg::IDX_W'(1);
    else if (int'(term_count) > tos_pkg::MAX_TERMS)
      nm1_in = tos_pkg::IDX_W'(tos_pkg::MAX_TERMS - 1);
    else
      nm1_in = tos_pkg::IDX_W'(term_count - 1'b1);
  end

  assign accept   = (state == S_IDLE) && in_valid;
  assign in_stall = (state != S_IDLE);

  // ---------------- issue stage ----------------
  always_comb begin
    iss.valid = (state == S_SQ) || ((state == S_CU) && !((i == k) && (hold != 2'd0)));
    iss.first = (i == '0);
    iss.last  = (i == k);
    iss.kind  = (state == S_CU) ? K_CU : K_SQ;
  end

  assign addr_a = (state == S_HMUL) ? hk : i;
  assign addr_b = k - i;

  // ---------------- memories ----------------
  assign c_we    = accept || (state == S_DCOEF);
  assign c_waddr = accept ? '0 : k + 1'b1;
  assign c_wdata = accept ? x_now : c_new;

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    rd_ca <= cmem[addr_a];
    rd_cb <= cmem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (sq_we) sqmem[k] <= sum_sat;
    rd_sq <= sqmem[i];
  end

  always_ff @(posedge clk) begin
    if (state == S_DCOEF) dcmem[k] <= tos_pkg::sat_val(dc_val);
    rd_dc <= dcmem[hk];
  end

  // ---------------- shared multiplier and accumulate ----------------
  always_comb begin
    if (state == S_HMUL) begin
      mul_a = hv;
      mul_b = h;
    end else begin
      mul_a = (ctl_b.kind == K_SQ) ? rd_ca : rd_sq;
      mul_b = rd_cb;
    end
  end

  assign q        = tos_pkg::q_round(prod);
  assign acc_base = ctl_c.first ? tos_pkg::ACC_W'(0) : acc;
  assign sum      = acc_base + q;
  assign sum_sat  = tos_pkg::sat_val(sum);
  assign sum_hit  = ctl_c.valid && ctl_c.last && tos_pkg::sat_hit(sum);
  assign sq_we    = ctl_c.valid && ctl_c.last && (ctl_c.kind == K_SQ);

  // ---------------- divide and derivative coefficient ----------------
  assign dnum = k + 1'b1;
  assign half = dnum >> 1;

  // |diff| + d/2 in one add: -diff is ~diff + 1
  always_comb begin
    if (diff[tos_pkg::DATA_W])
      mag = ~tos_pkg::DIV_IN_W'(diff) + tos_pkg::DIV_IN_W'(half) + 1'b1;
    else
      mag = tos_pkg::DIV_IN_W'(diff) + tos_pkg::DIV_IN_W'(half);
  end

  assign div_start = (state == S_PREP);

  tos_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (dnum),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_val = diff[tos_pkg::DATA_W] ? -$signed(tos_pkg::ACC_W'(div_q))
                                         :  $signed(tos_pkg::ACC_W'(div_q));
  assign dc_prod = c_new * $signed({1'b0, dnum});
  assign dc_val  = tos_pkg::ACC_W'(dc_prod);

  // ---------------- Horner ----------------
  assign term   = phase ? tos_pkg::ACC_W'(rd_dc) : tos_pkg::ACC_W'(rd_ca);
  assign hv_sum = q + term;
  assign hv_new = tos_pkg::sat_val(hv_sum);

  always_comb begin
    ovf_set = sum_hit;
    case (state)
      S_DIVW:  ovf_set = ovf_set || (div_done && tos_pkg::sat_hit(div_val));
      S_DCOEF: ovf_set = ovf_set || tos_pkg::sat_hit(dc_val);
      S_HADD:  ovf_set = ovf_set || tos_pkg::sat_hit(hv_sum);
      default: ovf_set = sum_hit;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step_size  <= tos_pkg::STEP_RST;
      backward   <= 1'b0;
      term_count <= tos_pkg::TERMS_RST;
      out_valid  <= 1'b0;
      ctl_b      <= '0;
      ctl_c      <= '0;
      cu_done    <= 1'b0;
      hold       <= '0;
      ovf        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          tos_pkg::REG_STEP:  step_size  <= pwdata[tos_pkg::STEP_W-1:0];
          tos_pkg::REG_DIR:   backward   <= pwdata[0];
          tos_pkg::REG_TERMS: term_count <= pwdata[tos_pkg::TC_W-1:0];
          default: ;
        endcase
      end

      // the final state loads the output register itself
      if (out_valid && !out_stall && (state != S_FIN)) out_valid <= 1'b0;
      if (hold != 2'd0) hold <= hold - 1'b1;

      // pipeline: read -> multiply -> accumulate
      ctl_b <= iss;
      ctl_c <= ctl_b;
      prod  <= mul_a * mul_b;
      if (ctl_c.valid) acc <= sum;
      cu_done <= ctl_c.valid && ctl_c.last && (ctl_c.kind == K_CU);
      if (sq_we) sq_last <= sum_sat;
      if (ctl_c.valid && ctl_c.last && (ctl_c.kind == K_CU)) cu_last <= sum_sat;

      ovf <= accept ? 1'b0 : (ovf || ovf_set);

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            k     <= '0;
            i     <= '0;
            nm1   <= nm1_in;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (i == k) begin
            i     <= '0;
            hold  <= HOLD_GAP;
            state <= S_CU;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_CU: begin
          // last cu term needs sq[k]; wait for its write
          if (iss.valid) begin
            if (i == k) state <= S_DRAIN;
            else        i     <= i + 1'b1;
          end
        end
        S_DRAIN: begin
          if (cu_done) begin
            if (k == nm1) begin
              hk    <= nm1;
              hv    <= '0;
              phase <= 1'b0;
              state <= S_HMUL;
            end else begin
              diff  <= $signed({sq_last[tos_pkg::DATA_W-1], sq_last})
                     - $signed({cu_last[tos_pkg::DATA_W-1], cu_last});
              state <= S_PREP;
            end
          end
        end
        S_PREP: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            c_new <= tos_pkg::sat_val(div_val);
            state <= S_DCOEF;
          end
        end
        S_DCOEF: begin
          k     <= k + 1'b1;
          i     <= '0;
          state <= S_SQ;
        end
        S_HMUL: state <= S_HADD;
        S_HADD: begin
          if (hk == '0) begin
            if (!phase) begin
              x_res <= hv_new;
              hv    <= '0;
              phase <= 1'b1;
              hk    <= nm1 - 1'b1;
              state <= S_HMUL;
            end else begin
              slope_res <= hv_new;
              state     <= S_FIN;
            end
          end else begin
            hv    <= hv_new;
            hk    <= hk - 1'b1;
            state <= S_HMUL;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            x_next     <= x_res;
            slope_next <= slope_res;
            overflow   <= ovf;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/taylor_ode_step_check.sv
module taylor_ode_step_check
  import tos_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] x_now,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] x_next,
  input  logic signed [DATA_W-1:0] slope_next,
  input  logic                     overflow,
  output int                       fail_count,
  output int                       pending,
  output int                       checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIM_HI = 64'sh7FFF_FFFF;
  localparam longint LIM_LO = -64'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] slope;
    logic                     sat;
  } step_out_t;

  logic [STEP_W-1:0] h_mag;
  logic              h_neg;
  logic [TC_W-1:0]   n_terms;

  step_out_t next_state_q[$];
  step_out_t want;
  int        errs = 0;
  int        done = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic longint clamp32(input longint v, inout bit hit);
    if (v > LIM_HI) begin
      hit = 1'b1;
      return LIM_HI;
    end
    if (v < LIM_LO) begin
      hit = 1'b1;
      return LIM_LO;
    end
    return v;
  endfunction

  // round to nearest, ties toward +inf
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint div_near(input longint v, input longint d);
    longint m, q;
    m = (v < 0) ? -v : v;
    q = (m + d / 2) / d;
    return (v < 0) ? -q : q;
  endfunction

  function automatic step_out_t taylor_advance(input logic signed [DATA_W-1:0] x,
                                               input logic [STEP_W-1:0]        hm,
                                               input logic                     neg,
                                               input logic [TC_W-1:0]          tc);
    longint    c[MAX_TERMS];
    longint    sq[MAX_TERMS];
    longint    cu[MAX_TERMS];
    longint    dc[MAX_TERMS];
    longint    acc, h, val, slope;
    int        n;
    bit        hit;
    step_out_t r;
    hit = 1'b0;
    n = int'(tc);
    if (n < 2) n = 2;
    if (n > MAX_TERMS) n = MAX_TERMS;
    c[0] = longint'(x);
    // the last square and cube terms are unused but may still saturate
    for (int k = 0; k < n; k++) begin
      if (k > 0) c[k] = clamp32(div_near(sq[k-1] - cu[k-1], longint'(k)), hit);
      acc = 0;
      for (int i = 0; i <= k; i++) acc += qmul(c[i], c[k-i]);
      sq[k] = clamp32(acc, hit);
      acc = 0;
      for (int i = 0; i <= k; i++) acc += qmul(sq[i], c[k-i]);
      cu[k] = clamp32(acc, hit);
    end
    for (int k = 0; k < n - 1; k++) dc[k] = clamp32(c[k+1] * longint'(k + 1), hit);
    h = neg ? -longint'(hm) : longint'(hm);
    val = 0;
    for (int k = n - 1; k >= 0; k--) val = clamp32(qmul(val, h) + c[k], hit);
    slope = 0;
    for (int k = n - 2; k >= 0; k--) slope = clamp32(qmul(slope, h) + dc[k], hit);
    r.value = val[DATA_W-1:0];
    r.slope = slope[DATA_W-1:0];
    r.sat   = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      h_mag   <= STEP_RST;
      h_neg   <= 1'b0;
      n_terms <= TERMS_RST;
      next_state_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_STEP:  h_mag   <= pwdata[STEP_W-1:0];
          REG_DIR:   h_neg   <= pwdata[0];
          REG_TERMS: n_terms <= pwdata[TC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        next_state_q.insert(next_state_q.size(),
                            taylor_advance(x_now, h_mag, h_neg, n_terms));
      if (out_valid && !out_stall) begin
        if (next_state_q.size() == 0) begin
          errs++;
          $error("result item with no expectation waiting: x_next %0d", x_next);
        end else begin
          want = next_state_q.pop_front();
          done++;
          if (x_next !== want.value) begin
            errs++;
            $error("x_next: expected %0d, got %0d", want.value, x_next);
          end
          if (slope_next !== want.slope) begin
            errs++;
            $error("slope_next: expected %0d, got %0d", want.slope, slope_next);
          end
          if (overflow !== want.sat) begin
            errs++;
            $error("overflow: expected %0b, got %0b", want.sat, overflow);
          end
        end
      end
    end
    pending    <= next_state_q.size();
    fail_count <= errs;
    checked    <= done;
  end

endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tos_pkg::*;

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 106;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0100_0000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                     clk;
  logic                     rst        = 1'b1;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [ADDR_W-1:0]        paddr      = '0;
  logic [31:0]              pwdata     = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] x_now      = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic signed [DATA_W-1:0] x_next;
  logic signed [DATA_W-1:0] slope_next;
  logic                     overflow;

  int fail_count;
  int pending;
  int checked;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int sent         = 0;
  int settings_cnt = 0;
  int cycle_cnt    = 0;

  taylor_ode_step_top dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_now      (x_now),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .x_next     (x_next),
    .slope_next (slope_next),
    .overflow   (overflow)
  );

  taylor_ode_step_check step_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_now      (x_now),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .x_next     (x_next),
    .slope_next (slope_next),
    .overflow   (overflow),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_x(input logic signed [DATA_W-1:0] x);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_now    <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // hold off the sender until every result is back and the block is idle
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // spare upper bits carry noise; the registers keep only their own width
  task automatic apply_settings(input logic [STEP_W-1:0] step, input logic back,
                                input logic [TC_W-1:0] terms, input idle_mode_t m);
    wait_results_done();
    case (m)
      IDLE_NONE: begin gap_pct <= 0;  stall_pct <= 0;  end
      IDLE_SEND: begin gap_pct <= 71; stall_pct <= 0;  end
      IDLE_RECV: begin gap_pct <= 0;  stall_pct <= 71; end
      IDLE_BOTH: begin gap_pct <= 35; stall_pct <= 35; end
      default:   begin gap_pct <= 0;  stall_pct <= 0;  end
    endcase
    reg_write(REG_STEP,  {1'($urandom), step});
    reg_write(REG_DIR,   {31'($urandom), back});
    reg_write(REG_TERMS, {27'($urandom), terms});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_cnt++;
  endtask

  initial begin
    logic [STEP_W-1:0]        step_v;
    logic [TC_W-1:0]          terms_v;
    logic signed [DATA_W-1:0] x_v;
    int                       r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: h = 0.1 forward, ten terms
    send_x('0);
    send_x(Q_ONE);
    send_x(-Q_ONE);
    send_x(Q_ONE >>> 1);
    send_x(Q_ONE <<< 1);
    send_x(32'sh7FFF_FFFF);
    send_x(32'sh8000_0000);
    send_x(32'sd1);
    send_x(-32'sd1);
    send_x(32'sh5555_5555);
    send_x(32'shAAAA_AAAA);

    // two terms, largest step, backward
    apply_settings('1, 1'b1, 5'd2, IDLE_NONE);
    send_x(Q_ONE >>> 1);
    send_x(-(Q_ONE * 3));
    // term count below the minimum, zero step
    apply_settings('0, 1'b0, 5'd0, IDLE_NONE);
    send_x(Q_ONE >>> 2);
    send_x(-(Q_ONE >>> 1));
    apply_settings(31'h0020_0000, 1'b1, 5'd1, IDLE_NONE);
    send_x((Q_ONE >>> 2) * 3);
    // full term count, then above the maximum
    apply_settings(31'h0010_0000, 1'b0, 5'd16, IDLE_NONE);
    send_x(Q_ONE >>> 1);
    send_x(-(Q_ONE >>> 2));
    apply_settings(31'h0019_999A, 1'b0, 5'd31, IDLE_NONE);
    send_x((Q_ONE >>> 1) * 3);
    apply_settings(31'h0008_0000, 1'b1, 5'd17, IDLE_NONE);
    send_x(-Q_ONE);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r = $urandom_range(99);
      if (r < 60)      step_v = STEP_W'($urandom_range(32'h0100_0000));
      else if (r < 85) step_v = STEP_W'($urandom);
      else             step_v = $urandom_range(1) ? '1 : '0;
      // mostly short polynomials keep the run brief
      terms_v = ($urandom_range(9) < 7) ? TC_W'($urandom_range(10, 2))
                                        : TC_W'($urandom_range(31));
      apply_settings(step_v, 1'($urandom), terms_v, idle_mode_t'(ph % 4));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(99) == 0) wait_results_done();
        r = $urandom_range(99);
        if (r < 40) begin
          x_v = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        end else if (r < 55) begin
          x_v = Q_ONE + $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
        end else if (r < 85) begin
          x_v = $urandom;
        end else begin
          case ($urandom_range(4))
            0:       x_v = '0;
            1:       x_v = Q_ONE;
            2:       x_v = -Q_ONE;
            3:       x_v = 32'sh7FFF_FFFF;
            default: x_v = 32'sh8000_0000;
          endcase
        end
        send_x(x_v);
      end
    end

    wait_results_done();
    repeat (600) @(posedge clk);

    $display("covered %0d x_now items over %0d register settings, term counts 0..31,",
             sent, settings_cnt);
    $display("both directions and all idling modes; %0d results compared, %0d mismatches",
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/tos_pkg.sv
sv/tos_div.sv
sv/taylor_ode_step_top.sv
dv/taylor_ode_step_check.sv
dv/tb.sv
